// ----- design/vnm_pkg.sv -----
// ----------------------------------------------------------------------------
// vnm_pkg
// Shared widths, hash constants, register indexes and types for the value
// noise normal map pixel pipeline.
// ----------------------------------------------------------------------------
package vnm_pkg;

	localparam int COORD_W     = 12;
	localparam int SIZE_W      = 13;
	localparam int MAX_SIZE    = 4096;
	localparam int SCALE_SHIFT = 18;                 // x * 4 * 2^16
	localparam int POS_FRAC_W  = 16;
	localparam int POS_W       = COORD_W + SCALE_SHIFT;
	localparam int CELL_W      = POS_W - POS_FRAC_W;
	localparam int WGT_W       = POS_FRAC_W + 1;     // weight reaches 1.0
	localparam int NOISE_W     = 16;
	localparam int AMP_W       = 16;
	localparam int SEED_W      = 32;
	localparam int HASH_W      = 32;
	localparam int HASH_LAT    = 6;
	localparam int SLOPE_W     = 25;
	localparam int RAD_W       = 50;
	localparam int ROOT_W      = 25;
	localparam int LEN_W       = ROOT_W + 1;
	localparam int CHAN_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [HASH_W-1:0] HASH_K_X    = 32'h9E3779B1;
	localparam logic [HASH_W-1:0] HASH_K_Y    = 32'h85EBCA77;
	localparam logic [HASH_W-1:0] HASH_K_SEED = 32'hC2B2AE3D;
	localparam logic [HASH_W-1:0] HASH_K_MIX1 = 32'h7FEB352D;
	localparam logic [HASH_W-1:0] HASH_K_MIX2 = 32'h846CA68B;

	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_SEED   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUMP_AMP     = 2'd2;

	localparam logic [SLOPE_W-1:0] UNIT_Q20 = SLOPE_W'(1 << 20);
	localparam logic [RAD_W-1:0]   RAD_BIAS = RAD_W'(64'd1 << 40);

	// signed slope in Q.20, sign and magnitude
	typedef struct packed {
		logic               neg;
		logic [SLOPE_W-1:0] mag;
	} slope_t;

endpackage

// ----- design/vnm_coord_div.sv -----
// ----------------------------------------------------------------------------
// vnm_coord_div
// Pipelined restoring divider: (coord << 18) / size for x and y, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module vnm_coord_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [vnm_pkg::COORD_W-1:0] coord_x,
	input  logic [vnm_pkg::COORD_W-1:0] coord_y,
	input  logic [vnm_pkg::SIZE_W-1:0]  divisor,
	output logic                        out_valid,
	output logic [vnm_pkg::POS_W-1:0]   pos_x,
	output logic [vnm_pkg::POS_W-1:0]   pos_y
);
	import vnm_pkg::*;

	localparam int STAGES = POS_W;

	logic [SIZE_W-1:0] rem_s [STAGES][2];
	logic [POS_W-1:0]  acc_s [STAGES][2];
	logic              vld_s [STAGES];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [SIZE_W-1:0] rem_in [2];
		logic [POS_W-1:0]  acc_in [2];
		logic              v_in;
		logic [SIZE_W:0]   trial  [2];
		logic              fits   [2];
		logic [SIZE_W-1:0] rem_nx [2];
		logic [POS_W-1:0]  acc_nx [2];

		if (k == 0) begin : g_head
			always_comb begin
				rem_in[0] = '0;
				rem_in[1] = '0;
				acc_in[0] = {coord_x, {SCALE_SHIFT{1'b0}}};
				acc_in[1] = {coord_y, {SCALE_SHIFT{1'b0}}};
				v_in      = in_valid;
			end
		end else begin : g_body
			always_comb begin
				rem_in[0] = rem_s[k-1][0];
				rem_in[1] = rem_s[k-1][1];
				acc_in[0] = acc_s[k-1][0];
				acc_in[1] = acc_s[k-1][1];
				v_in      = vld_s[k-1];
			end
		end

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l]  = {rem_in[l], acc_in[l][POS_W-1]};
				fits[l]   = trial[l] >= {1'b0, divisor};
				rem_nx[l] = fits[l] ? SIZE_W'(trial[l] - {1'b0, divisor})
				                    : trial[l][SIZE_W-1:0];
				acc_nx[l] = {acc_in[l][POS_W-2:0], fits[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 2; l++) begin
					rem_s[k][l] <= rem_nx[l];
					acc_s[k][l] <= acc_nx[l];
				end
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign pos_x     = acc_s[STAGES-1][0];
	assign pos_y     = acc_s[STAGES-1][1];

endmodule

// ----- design/vnm_hash.sv -----
// ----------------------------------------------------------------------------
// vnm_hash
// Six-stage lattice corner hash, 16 bits out (low half xor high half).
// ----------------------------------------------------------------------------
module vnm_hash (
	input  logic                        clk,
	input  logic                        en,
	input  logic [vnm_pkg::HASH_W-1:0]  cx,
	input  logic [vnm_pkg::HASH_W-1:0]  cy,
	input  logic [vnm_pkg::HASH_W-1:0]  seed_mul,
	output logic [vnm_pkg::NOISE_W-1:0] noise
);
	import vnm_pkg::*;

	logic [HASH_W-1:0]  rot_s1, ymul_s1, h_s2, m_s3, h_s4, m_s5;
	logic [NOISE_W-1:0] n_s6;
	logic [HASH_W-1:0]  x_mix, h2_sum;

	assign x_mix  = cx ^ HASH_K_X;
	assign h2_sum = (rot_s1 + ymul_s1) ^ seed_mul;

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1  <= {x_mix[18:0], x_mix[31:19]};
			ymul_s1 <= cy * HASH_K_Y;
			h_s2    <= h2_sum ^ (h2_sum >> 16);
			m_s3    <= h_s2 * HASH_K_MIX1;
			h_s4    <= m_s3 ^ (m_s3 >> 15);
			m_s5    <= h_s4 * HASH_K_MIX2;
			n_s6    <= m_s5[15:0] ^ m_s5[31:16];
		end
	end

	assign noise = n_s6;

endmodule

// ----- design/vnm_slope.sv -----
// ----------------------------------------------------------------------------
// vnm_slope
// One value-noise sample: four corner hashes, bilinear blend, mapping to
// -1..1 and amplitude scaling to a rounded Q.20 slope.
// ----------------------------------------------------------------------------
module vnm_slope (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [vnm_pkg::CELL_W-1:0] cell_x,
	input  logic [vnm_pkg::CELL_W-1:0] cell_y,
	input  logic [vnm_pkg::WGT_W-1:0]  wgt_x,
	input  logic [vnm_pkg::WGT_W-1:0]  wgt_y,
	input  logic [vnm_pkg::HASH_W-1:0] seed_mul,
	input  logic [vnm_pkg::AMP_W-1:0]  amp,
	output logic                       out_valid,
	output vnm_pkg::slope_t            slope
);
	import vnm_pkg::*;

	localparam logic [WGT_W-1:0] W_ONE   = WGT_W'(1 << POS_FRAC_W);
	localparam logic [50:0]      MID     = 51'(65535) << 32;
	localparam logic [63:0]      HALF_DEN = 64'(65535) << 23;
	localparam logic [40:0]      DIV_K   = 41'(65535);

	logic [HASH_W-1:0]  cx0, cx1, cy0, cy1;
	logic [NOISE_W-1:0] n00, n10, n01, n11;

	assign cx0 = HASH_W'(cell_x);
	assign cx1 = HASH_W'(cell_x) + HASH_W'(1);
	assign cy0 = HASH_W'(cell_y);
	assign cy1 = HASH_W'(cell_y) + HASH_W'(1);

	vnm_hash u_h00 (.clk, .en, .cx(cx0), .cy(cy0), .seed_mul, .noise(n00));
	vnm_hash u_h10 (.clk, .en, .cx(cx1), .cy(cy0), .seed_mul, .noise(n10));
	vnm_hash u_h01 (.clk, .en, .cx(cx0), .cy(cy1), .seed_mul, .noise(n01));
	vnm_hash u_h11 (.clk, .en, .cx(cx1), .cy(cy1), .seed_mul, .noise(n11));

	// weights and valid ride alongside the hash pipe
	logic [WGT_W-1:0] wx_dly_s [HASH_LAT];
	logic [WGT_W-1:0] wy_dly_s [HASH_LAT];
	logic             v_dly_s  [HASH_LAT];

	logic [32:0]        top_s1, bot_s1;
	logic [WGT_W-1:0]   wy_s1;
	logic [49:0]        val_s2;
	logic [47:0]        mag_s3;
	logic [39:0]        a_s4, a_s5;
	logic [SLOPE_W-1:0] q_s5;
	logic               neg_s3, neg_s4, neg_s5;
	slope_t             slope_s6;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [WGT_W-1:0]   wx_b, inv_wx, inv_wy;
	logic [32:0]        top_nx, bot_nx;
	logic [49:0]        val_nx;
	logic [50:0]        twice;
	logic [63:0]        prod_t;
	logic [41:0]        q_sum;
	logic [40:0]        back, resid;

	assign wx_b   = wx_dly_s[HASH_LAT-1];
	assign inv_wx = W_ONE - wx_b;
	assign inv_wy = W_ONE - wy_s1;
	assign top_nx = ({17'b0, n00} * {16'b0, inv_wx}) + ({17'b0, n10} * {16'b0, wx_b});
	assign bot_nx = ({17'b0, n01} * {16'b0, inv_wx}) + ({17'b0, n11} * {16'b0, wx_b});
	assign val_nx = ({17'b0, top_s1} * {33'b0, inv_wy}) + ({17'b0, bot_s1} * {33'b0, wy_s1});
	assign twice  = {val_s2, 1'b0};
	assign prod_t = ({16'b0, mag_s3} * {48'b0, amp}) + HALF_DEN;
	// floor estimate of a/65535, never high and at most one low
	assign q_sum  = {2'b0, a_s4} + 42'(a_s4 >> 16) + 42'(a_s4 >> 32);
	assign back   = {q_s5, 16'b0} - 41'(q_s5);
	assign resid  = {1'b0, a_s5} - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_LAT; i++) v_dly_s[i] <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			v_dly_s[0] <= in_valid;
			for (int i = 1; i < HASH_LAT; i++) v_dly_s[i] <= v_dly_s[i-1];
			vld_s1 <= v_dly_s[HASH_LAT-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_dly_s[0] <= wgt_x;
			wy_dly_s[0] <= wgt_y;
			for (int i = 1; i < HASH_LAT; i++) begin
				wx_dly_s[i] <= wx_dly_s[i-1];
				wy_dly_s[i] <= wy_dly_s[i-1];
			end
			top_s1 <= top_nx;
			bot_s1 <= bot_nx;
			wy_s1  <= wy_dly_s[HASH_LAT-1];
			val_s2 <= val_nx;
			neg_s3 <= twice < MID;
			mag_s3 <= (twice < MID) ? 48'(MID - twice) : 48'(twice - MID);
			a_s4   <= prod_t[63:24];
			neg_s4 <= neg_s3;
			a_s5   <= a_s4;
			q_s5   <= q_sum[40:16];
			neg_s5 <= neg_s4;
			slope_s6.neg <= neg_s5;
			slope_s6.mag <= (resid >= DIV_K) ? q_s5 + SLOPE_W'(1) : q_s5;
		end
	end

	assign out_valid = vld_s6;
	assign slope     = slope_s6;

endmodule

// ----- design/vnm_sqrt.sv -----
// ----------------------------------------------------------------------------
// vnm_sqrt
// Pipelined digit-by-digit square root, one root bit per stage, then round
// to nearest. Carries both slopes along.
// ----------------------------------------------------------------------------
module vnm_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [vnm_pkg::RAD_W-1:0] rad,
	input  vnm_pkg::slope_t           slope_x,
	input  vnm_pkg::slope_t           slope_y,
	output logic                      out_valid,
	output logic [vnm_pkg::LEN_W-1:0] len,
	output vnm_pkg::slope_t           out_slope_x,
	output vnm_pkg::slope_t           out_slope_y
);
	import vnm_pkg::*;

	localparam int REM_W = ROOT_W + 2;

	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	slope_t            sx_s   [ROOT_W];
	slope_t            sy_s   [ROOT_W];
	logic              vld_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		slope_t            sx_in, sy_in;
		logic              v_in;
		logic [REM_W+1:0]  nx, trial;
		logic              fits;

		if (k == 0) begin : g_head
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign sx_in   = slope_x;
			assign sy_in   = slope_y;
			assign v_in    = in_valid;
		end else begin : g_body
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign sx_in   = sx_s[k-1];
			assign sy_in   = sy_s[k-1];
			assign v_in    = vld_s[k-1];
		end

		assign nx    = {rem_in, rad_in[RAD_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign fits  = nx >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= fits ? REM_W'(nx - trial) : nx[REM_W-1:0];
				root_s[k] <= {root_in[ROOT_W-2:0], fits};
				rad_s[k]  <= {rad_in[RAD_W-3:0], 2'b00};
				sx_s[k]   <= sx_in;
				sy_s[k]   <= sy_in;
			end
		end
	end

	// round: bump when remainder exceeds the root
	logic [LEN_W-1:0] len_s;
	slope_t           sx_r_s, sy_r_s;
	logic             vld_r_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r_s <= 1'b0;
		end else if (en) begin
			vld_r_s <= vld_s[ROOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s  <= {1'b0, root_s[ROOT_W-1]}
			        + LEN_W'(rem_s[ROOT_W-1] > {2'b00, root_s[ROOT_W-1]});
			sx_r_s <= sx_s[ROOT_W-1];
			sy_r_s <= sy_s[ROOT_W-1];
		end
	end

	assign out_valid   = vld_r_s;
	assign len         = len_s;
	assign out_slope_x = sx_r_s;
	assign out_slope_y = sy_r_s;

endmodule

// ----- design/vnm_encode.sv -----
// ----------------------------------------------------------------------------
// vnm_encode
// Channel encoding floor((510*(L+c) + 2L) / 4L) for three channels, one
// quotient bit per stage. The last stage is the output register.
// ----------------------------------------------------------------------------
module vnm_encode (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [vnm_pkg::LEN_W-1:0]  len,
	input  vnm_pkg::slope_t            slope_x,
	input  vnm_pkg::slope_t            slope_y,
	output logic                       out_valid,
	output logic [vnm_pkg::CHAN_W-1:0] red,
	output logic [vnm_pkg::CHAN_W-1:0] green,
	output logic [vnm_pkg::CHAN_W-1:0] blue
);
	import vnm_pkg::*;

	localparam int CHANS  = 3;
	localparam int SUM_W  = LEN_W + 1;
	localparam int NUM_W  = SUM_W + 9;
	localparam int DEN_W  = LEN_W + 2;
	localparam int STAGES = CHAN_W;

	slope_t           ch_slope [CHANS];
	logic [SUM_W-1:0] sum      [CHANS];
	logic [NUM_W-1:0] num_p    [CHANS];
	logic [DEN_W-1:0] den_p;
	logic             vld_p;

	assign ch_slope[0] = slope_x;
	assign ch_slope[1] = slope_y;
	assign ch_slope[2] = '{neg: 1'b0, mag: UNIT_Q20};

	always_comb begin
		for (int c = 0; c < CHANS; c++) begin
			sum[c] = ch_slope[c].neg ? SUM_W'(len) - SUM_W'(ch_slope[c].mag)
			                         : SUM_W'(len) + SUM_W'(ch_slope[c].mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= 1'b0;
		end else if (en) begin
			vld_p <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < CHANS; c++) begin
				num_p[c] <= {sum[c], 9'b0} - NUM_W'({sum[c], 1'b0})
				          + NUM_W'({len, 1'b0});
			end
			den_p <= {len, 2'b00};
		end
	end

	logic [NUM_W-1:0]  rem_s [STAGES][CHANS];
	logic [CHAN_W-1:0] q_s   [STAGES][CHANS];
	logic [DEN_W-1:0]  den_s [STAGES];
	logic              vld_s [STAGES];

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		logic [NUM_W-1:0]  rem_in [CHANS];
		logic [CHAN_W-1:0] q_in   [CHANS];
		logic [DEN_W-1:0]  den_in;
		logic              v_in;
		logic [NUM_W-1:0]  cmp;
		logic              fits   [CHANS];

		if (j == 0) begin : g_head
			always_comb begin
				for (int c = 0; c < CHANS; c++) begin
					rem_in[c] = num_p[c];
					q_in[c]   = '0;
				end
				den_in = den_p;
				v_in   = vld_p;
			end
		end else begin : g_body
			always_comb begin
				for (int c = 0; c < CHANS; c++) begin
					rem_in[c] = rem_s[j-1][c];
					q_in[c]   = q_s[j-1][c];
				end
				den_in = den_s[j-1];
				v_in   = vld_s[j-1];
			end
		end

		assign cmp = NUM_W'(den_in) << (STAGES - 1 - j);

		always_comb begin
			for (int c = 0; c < CHANS; c++) fits[c] = rem_in[c] >= cmp;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < CHANS; c++) begin
					rem_s[j][c] <= fits[c] ? rem_in[c] - cmp : rem_in[c];
					q_s[j][c]   <= {q_in[c][CHAN_W-2:0], fits[c]};
				end
				den_s[j] <= den_in;
			end
		end
	end

	assign out_valid = vld_s[STAGES-1];
	assign red       = q_s[STAGES-1][0];
	assign green     = q_s[STAGES-1][1];
	assign blue      = q_s[STAGES-1][2];

endmodule

// ----- design/value_noise_normal_map_pixel.sv -----
// ----------------------------------------------------------------------------
// value_noise_normal_map_pixel
// Procedural normal map texel generator: pixel position in, RGB normal out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   tvalid / tready    tdata[11:0] pixel_x, [23:12] pixel_y
//  m_*      out  tvalid / tready    tdata[7:0] red, [15:8] green, [23:16] blue
//  cfg_*    in   valid / ready      index 0 size, 1 seed, 2 amplitude
//
//  One texel per clock sustained while the output is not stalled; stages in
//  order: coordinate divide, smoothstep, hash and blend, length squared,
//  square root, channel divide. One transaction in flight per stage.
//  Asynchronous reset clears valid bits and sets config registers to defaults.
//  Whole pipeline advances together; m_tready low with m_tvalid high freezes
//  every stage, so s_tready drops only while the output register holds an
//  untaken texel. Config writes are always accepted; cfg_ready is tied high.
// ----------------------------------------------------------------------------
module value_noise_normal_map_pixel (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [vnm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [vnm_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel stream in
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [23:0]                    s_tdata,   // pixel_x, pixel_y
	// texel stream out
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata    // red, green, blue
);
	import vnm_pkg::*;

	// ---- configuration registers ----
	logic [SIZE_W-1:0] texture_size_q;
	logic [SEED_W-1:0] noise_seed_q;
	logic [AMP_W-1:0]  bump_amp_q;
	logic [HASH_W-1:0] seed_mul_x_q, seed_mul_y_q;
	logic [SIZE_W-1:0] size_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texture_size_q <= SIZE_W'(256);
			noise_seed_q   <= '0;
			bump_amp_q     <= AMP_W'(4096);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEXTURE_SIZE: texture_size_q <= cfg_data[SIZE_W-1:0];
				REG_NOISE_SEED:   noise_seed_q   <= cfg_data[SEED_W-1:0];
				REG_BUMP_AMP:     bump_amp_q     <= cfg_data[AMP_W-1:0];
				default:          ;
			endcase
		end
	end

	// seed terms of the hash; first read many stages after entry
	always_ff @(posedge clk) begin
		seed_mul_x_q <= noise_seed_q * HASH_K_SEED;
		seed_mul_y_q <= (noise_seed_q + SEED_W'(1)) * HASH_K_SEED;
	end

	// zero size reads as 1, oversize saturates
	assign size_eff = (texture_size_q == '0) ? SIZE_W'(1) :
	                  (texture_size_q > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) :
	                  texture_size_q;

	// ---- global advance ----
	logic en;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---- sample position ----
	logic             div_vld;
	logic [POS_W-1:0] pos_x, pos_y;

	vnm_coord_div u_div (
		.clk, .arst_n, .en,
		.in_valid (s_tvalid),
		.coord_x  (s_tdata[COORD_W-1:0]),
		.coord_y  (s_tdata[2*COORD_W-1:COORD_W]),
		.divisor  (size_eff),
		.out_valid(div_vld),
		.pos_x, .pos_y
	);

	// ---- smoothstep weights: f*f, then times (3 - 2f) ----
	logic [POS_FRAC_W-1:0] fx, fy;
	logic [31:0]           fsq_x_s1, fsq_y_s1;
	logic [17:0]           g_x_s1, g_y_s1;
	logic [CELL_W-1:0]     cell_x_s1, cell_y_s1, cell_x_s2, cell_y_s2;
	logic [WGT_W-1:0]      w_x_s2, w_y_s2;
	logic                  vld_s1, vld_s2;
	logic [49:0]           fade_x, fade_y;

	assign fx     = pos_x[POS_FRAC_W-1:0];
	assign fy     = pos_y[POS_FRAC_W-1:0];
	assign fade_x = {18'b0, fsq_x_s1} * {32'b0, g_x_s1};
	assign fade_y = {18'b0, fsq_y_s1} * {32'b0, g_y_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= div_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fsq_x_s1  <= {16'b0, fx} * {16'b0, fx};
			fsq_y_s1  <= {16'b0, fy} * {16'b0, fy};
			g_x_s1    <= 18'(196608) - {1'b0, fx, 1'b0};
			g_y_s1    <= 18'(196608) - {1'b0, fy, 1'b0};
			cell_x_s1 <= pos_x[POS_W-1:POS_FRAC_W];
			cell_y_s1 <= pos_y[POS_W-1:POS_FRAC_W];
			w_x_s2    <= fade_x[48:32];
			w_y_s2    <= fade_y[48:32];
			cell_x_s2 <= cell_x_s1;
			cell_y_s2 <= cell_y_s1;
		end
	end

	// ---- two noise samples: seed for x slope, seed+1 for y slope ----
	logic   slx_vld, sly_vld;
	slope_t slope_x, slope_y;

	vnm_slope u_slope_x (
		.clk, .arst_n, .en,
		.in_valid (vld_s2),
		.cell_x   (cell_x_s2), .cell_y(cell_y_s2),
		.wgt_x    (w_x_s2),    .wgt_y (w_y_s2),
		.seed_mul (seed_mul_x_q),
		.amp      (bump_amp_q),
		.out_valid(slx_vld),
		.slope    (slope_x)
	);

	vnm_slope u_slope_y (
		.clk, .arst_n, .en,
		.in_valid (vld_s2),
		.cell_x   (cell_x_s2), .cell_y(cell_y_s2),
		.wgt_x    (w_x_s2),    .wgt_y (w_y_s2),
		.seed_mul (seed_mul_y_q),
		.amp      (bump_amp_q),
		.out_valid(sly_vld),
		.slope    (slope_y)
	);

	// ---- squared length cx^2 + cy^2 + 1 ----
	logic [RAD_W-1:0] sq_x_s3, sq_y_s3, rad_s4;
	slope_t           sx_s3, sy_s3, sx_s4, sy_s4;
	logic             vld_s3, vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= slx_vld && sly_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s3 <= {25'b0, slope_x.mag} * {25'b0, slope_x.mag};
			sq_y_s3 <= {25'b0, slope_y.mag} * {25'b0, slope_y.mag};
			sx_s3   <= slope_x;
			sy_s3   <= slope_y;
			rad_s4  <= sq_x_s3 + sq_y_s3 + RAD_BIAS;
			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;
		end
	end

	// ---- rounded length ----
	logic             len_vld;
	logic [LEN_W-1:0] len;
	slope_t           sx_l, sy_l;

	vnm_sqrt u_sqrt (
		.clk, .arst_n, .en,
		.in_valid   (vld_s4),
		.rad        (rad_s4),
		.slope_x    (sx_s4),
		.slope_y    (sy_s4),
		.out_valid  (len_vld),
		.len,
		.out_slope_x(sx_l),
		.out_slope_y(sy_l)
	);

	// ---- channel encode, ends in the output register ----
	logic [CHAN_W-1:0] red, green, blue;

	vnm_encode u_enc (
		.clk, .arst_n, .en,
		.in_valid (len_vld),
		.len,
		.slope_x  (sx_l),
		.slope_y  (sy_l),
		.out_valid(m_tvalid),
		.red, .green, .blue
	);

	assign m_tdata = {blue, green, red};

endmodule
